FILE: design/yay0_pkg.sv
// Shared types and constants for the Yay0 decoder core.
// No dependencies; every other design file but yay0_ram imports this package.
package yay0_pkg;

	// Field and state widths
	localparam int POS_W      = 24;
	localparam int MASK_W     = 32;
	localparam int LINK_W     = 16;
	localparam int BYTE_W     = 8;
	localparam int DATA_W     = 64;
	localparam int CNT_W      = 4;
	localparam int BITS_W     = 6;
	localparam int LEN_W      = 9;
	localparam int DIST_W     = 13;
	localparam int OFFS_W     = 12;
	localparam int CODE_W     = 4;
	localparam int SLOT_W     = 3;

	// History buffer
	localparam int HIST_DEPTH = 4096;
	localparam int HIST_AW    = $clog2(HIST_DEPTH);

	// Default lane packing (bytes per result)
	localparam int LANE_BYTES_DEF = 8;

	// Length coding of a link halfword
	localparam int LEN_BIAS = 2;
	localparam int EXT_BIAS = 18;

	// Request opcodes
	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_DECODE = 1'b1;

	// Controller to datapath commands
	typedef struct packed {
		logic accept_en;  // feed channel may take a request
		logic single_out; // finish a one-result request
		logic setup_copy; // start a back-copy
		logic issue;      // read one history byte
		logic flush_out;  // hand a packed lane to the result register
	} ctrl_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic item_taken; // request accepted this cycle
		logic single;     // latched request yields exactly one result
		logic out_free;   // result register can load this cycle
		logic can_issue;  // lane has room and copy has bytes left
		logic s1_busy;    // a history read is in flight
		logic rem_zero;   // copy fully issued
	} dp_status_t;

endpackage

FILE: design/yay0_in_if.sv
// Request channel of the Yay0 decoder: heads of the three compressed streams.
// Depends on yay0_pkg for field widths.
interface yay0_in_if;
	import yay0_pkg::*;

	logic                valid;
	logic                ready;
	logic                op;
	logic [MASK_W-1:0]   mask_word;
	logic [LINK_W-1:0]   link_word;
	logic [BYTE_W-1:0]   chunk_byte;

	modport source (output valid, op, mask_word, link_word, chunk_byte, input ready);
	modport sink   (input valid, op, mask_word, link_word, chunk_byte, output ready);
endinterface

FILE: design/yay0_out_if.sv
// Result channel of the Yay0 decoder: packed bytes and stream status flags.
// Depends on yay0_pkg for field widths.
interface yay0_out_if;
	import yay0_pkg::*;

	logic                valid;
	logic                ready;
	logic [DATA_W-1:0]   data_bytes;
	logic [CNT_W-1:0]    byte_count;
	logic                last_of_run;
	logic                took_chunk;
	logic                took_link;
	logic                needs_mask;
	logic                done_res;
	logic                distance_error;

	modport source (output valid, data_bytes, byte_count, last_of_run, took_chunk,
		took_link, needs_mask, done_res, distance_error, input ready);
	modport sink   (input valid, data_bytes, byte_count, last_of_run, took_chunk,
		took_link, needs_mask, done_res, distance_error, output ready);
endinterface

FILE: design/yay0_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read during write to the same address returns the old contents. No dependencies.
module yay0_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// Storage array and read register
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

FILE: design/yay0_ctrl.sv
// Sequencing state machine of the Yay0 decoder: dispatch, history reads, lane flush.
// Depends on yay0_pkg for the command and status structs.
module yay0_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  yay0_pkg::dp_status_t stat,
	output yay0_pkg::ctrl_cmd_t  cmd
);
	import yay0_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DISPATCH,
		ST_READ,
		ST_FLUSH
	} state_t;

	state_t state_q;
	logic   ready_q;

	// State register and registered request-ready
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ready_q <= 1'b1;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (stat.item_taken) begin
						state_q <= ST_DISPATCH;
						ready_q <= 1'b0;
					end
				end
				ST_DISPATCH: begin
					if (!stat.single) begin
						state_q <= ST_READ;
					end else if (stat.out_free) begin
						state_q <= ST_IDLE;
						ready_q <= 1'b1;
					end
				end
				ST_READ: begin
					if (!stat.can_issue) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					if (!stat.s1_busy && stat.out_free) begin
						if (stat.rem_zero) begin
							state_q <= ST_IDLE;
							ready_q <= 1'b1;
						end else begin
							state_q <= ST_READ;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
					ready_q <= 1'b1;
				end
			endcase
		end
	end

	// Command decode
	always_comb begin
		cmd            = '0;
		cmd.accept_en  = ready_q;
		unique case (state_q)
			ST_IDLE: begin
			end
			ST_DISPATCH: begin
				cmd.single_out = stat.single && stat.out_free;
				cmd.setup_copy = !stat.single;
			end
			ST_READ: begin
				cmd.issue = stat.can_issue;
			end
			ST_FLUSH: begin
				cmd.flush_out = !stat.s1_busy && stat.out_free;
			end
			default: begin
			end
		endcase
	end

endmodule

FILE: design/yay0_dp.sv
// Datapath of the Yay0 decoder: request latch, mask and position state, copy
// engine over the history RAM, lane packing and result register.
// Depends on yay0_pkg, yay0_in_if, yay0_out_if and yay0_ram.
module yay0_dp #(
	parameter int LANE_BYTES = yay0_pkg::LANE_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	yay0_in_if.sink                     feed,
	yay0_out_if.source                  result,
	input  logic                        cfg_wr_en,
	input  logic [yay0_pkg::POS_W-1:0]  cfg_wr_data,
	input  yay0_pkg::ctrl_cmd_t         cmd,
	output yay0_pkg::dp_status_t        stat
);
	import yay0_pkg::*;

	// Latched request
	logic              op_q;
	logic [MASK_W-1:0] mask_word_q;
	logic [LINK_W-1:0] link_q;
	logic [BYTE_W-1:0] chunk_q;

	// Decoder state
	logic [POS_W-1:0]  size_q;
	logic [POS_W-1:0]  pos_q;
	logic [MASK_W-1:0] mask_q;
	logic [BITS_W-1:0] bits_q;

	// Copy engine
	logic [DIST_W-1:0] dist_q;
	logic [LEN_W-1:0]  rem_q;
	logic [POS_W-1:0]  rd_pos_q;
	logic [CNT_W-1:0]  cnt_q;
	logic              err_q;
	logic              tc_q;
	logic              first_q;
	logic [DATA_W-1:0] lane_q;
	logic [BYTE_W-1:0] prev_q;

	// Read stage
	logic              s1_valid_s1;
	logic              s1_zero_s1;
	logic              s1_fwd_s1;
	logic [SLOT_W-1:0] s1_slot_s1;

	// Result register
	logic              out_valid_q;
	logic [DATA_W-1:0] out_data_q;
	logic [CNT_W-1:0]  out_count_q;
	logic              out_last_q;
	logic              out_tc_q;
	logic              out_tl_q;
	logic              out_nm_q;
	logic              out_done_q;
	logic              out_err_q;

	logic              capture;
	logic              is_load;
	logic              done_now;
	logic              no_bits;
	logic              literal;
	logic              lit_write;
	logic [CODE_W-1:0] code;
	logic [DIST_W-1:0] link_dist;
	logic [LEN_W-1:0]  len_raw;
	logic [LEN_W-1:0]  len_clip;
	logic [POS_W-1:0]  remain;
	logic              dist_err;
	logic [BITS_W-1:0] single_bits;
	logic [POS_W-1:0]  single_pos;
	logic [BYTE_W-1:0] copy_byte;
	logic              out_free;

	logic              ram_we;
	logic [HIST_AW-1:0] ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;
	logic [HIST_AW-1:0] ram_raddr;
	logic [BYTE_W-1:0] ram_rdata;

	// Request handshake
	assign feed.ready = cmd.accept_en;
	assign capture    = feed.valid && cmd.accept_en;

	always_ff @(posedge clk) begin
		if (capture) begin
			op_q        <= feed.op;
			mask_word_q <= feed.mask_word;
			link_q      <= feed.link_word;
			chunk_q     <= feed.chunk_byte;
		end
	end

	// Request classification and link decode
	assign is_load  = (op_q == OP_LOAD);
	assign done_now = (pos_q >= size_q);
	assign no_bits  = (bits_q == '0);
	assign literal  = mask_q[MASK_W-1];
	assign lit_write = cmd.single_out && !is_load && !done_now && !no_bits;

	assign code      = link_q[LINK_W-1 -: CODE_W];
	assign link_dist = DIST_W'(link_q[OFFS_W-1:0]) + DIST_W'(1);
	assign len_raw  = (code == '0) ? (LEN_W'(chunk_q) + LEN_W'(EXT_BIAS))
	                               : (LEN_W'(code) + LEN_W'(LEN_BIAS));
	assign remain   = size_q - pos_q;
	assign len_clip = (remain < POS_W'(len_raw)) ? remain[LEN_W-1:0] : len_raw;
	assign dist_err = (POS_W'(link_dist) > pos_q);

	// State after a one-result request
	always_comb begin
		single_bits = bits_q;
		single_pos  = pos_q;
		if (is_load) begin
			single_bits = BITS_W'(MASK_W);
		end else if (!done_now && !no_bits) begin
			single_bits = bits_q - BITS_W'(1);
			single_pos  = pos_q + POS_W'(1);
		end
	end

	// Copied byte: zero before the start of output, forwarded when the source
	// is the byte written in the same cycle as this read
	always_comb begin
		if (s1_zero_s1) begin
			copy_byte = '0;
		end else if (s1_fwd_s1) begin
			copy_byte = prev_q;
		end else begin
			copy_byte = ram_rdata;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= '0;
		end else if (cfg_wr_en) begin
			size_q <= cfg_wr_data;
		end
	end

	// Mask, bit count and output position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
			bits_q <= '0;
			pos_q  <= '0;
		end else begin
			if (cmd.single_out) begin
				if (is_load) begin
					mask_q <= mask_word_q;
				end else if (!done_now && !no_bits) begin
					mask_q <= mask_q << 1;
				end
				bits_q <= single_bits;
				pos_q  <= single_pos;
			end else if (cmd.setup_copy) begin
				mask_q <= mask_q << 1;
				bits_q <= bits_q - BITS_W'(1);
			end else if (s1_valid_s1) begin
				pos_q <= pos_q + POS_W'(1);
			end
		end
	end

	// Copy engine control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q       <= '0;
			cnt_q       <= '0;
			first_q     <= 1'b0;
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= cmd.issue;
			if (cmd.setup_copy) begin
				rem_q   <= len_clip;
				cnt_q   <= '0;
				first_q <= 1'b1;
			end else if (cmd.issue) begin
				rem_q <= rem_q - LEN_W'(1);
				cnt_q <= cnt_q + CNT_W'(1);
			end else if (cmd.flush_out) begin
				cnt_q   <= '0;
				first_q <= 1'b0;
			end
		end
	end

	// Copy engine payload
	always_ff @(posedge clk) begin
		if (cmd.setup_copy) begin
			dist_q   <= link_dist;
			err_q    <= dist_err;
			tc_q     <= (code == '0);
			rd_pos_q <= pos_q;
			lane_q   <= '0;
		end else if (cmd.flush_out) begin
			lane_q <= '0;
		end else if (s1_valid_s1) begin
			lane_q[{s1_slot_s1, 3'b000} +: BYTE_W] <= copy_byte;
		end
		if (cmd.issue) begin
			rd_pos_q   <= rd_pos_q + POS_W'(1);
			s1_zero_s1 <= (rd_pos_q < POS_W'(dist_q));
			s1_fwd_s1  <= (cnt_q != '0) && (dist_q == DIST_W'(1));
			s1_slot_s1 <= cnt_q[SLOT_W-1:0];
		end
		if (s1_valid_s1) begin
			prev_q <= copy_byte;
		end
	end

	// History RAM ports
	assign ram_we    = lit_write || s1_valid_s1;
	assign ram_waddr = pos_q[HIST_AW-1:0];
	assign ram_wdata = s1_valid_s1 ? copy_byte : chunk_q;
	assign ram_raddr = rd_pos_q[HIST_AW-1:0] - dist_q[HIST_AW-1:0];

	yay0_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(HIST_DEPTH)
	) u_hist (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// Result register
	assign out_free = !out_valid_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.single_out || cmd.flush_out) begin
			out_valid_q <= 1'b1;
		end else if (result.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.single_out) begin
			out_data_q  <= lit_write ? DATA_W'(chunk_q) : '0;
			out_count_q <= lit_write ? CNT_W'(1) : '0;
			out_last_q  <= 1'b1;
			out_tc_q    <= lit_write;
			out_tl_q    <= 1'b0;
			out_nm_q    <= (single_bits == '0);
			out_done_q  <= (single_pos >= size_q);
			out_err_q   <= 1'b0;
		end else if (cmd.flush_out) begin
			out_data_q  <= lane_q;
			out_count_q <= cnt_q;
			out_last_q  <= (rem_q == '0);
			out_tc_q    <= first_q && tc_q;
			out_tl_q    <= first_q;
			out_nm_q    <= (bits_q == '0);
			out_done_q  <= (pos_q >= size_q);
			out_err_q   <= err_q;
		end
	end

	assign result.valid          = out_valid_q;
	assign result.data_bytes     = out_data_q;
	assign result.byte_count     = out_count_q;
	assign result.last_of_run    = out_last_q;
	assign result.took_chunk     = out_tc_q;
	assign result.took_link      = out_tl_q;
	assign result.needs_mask     = out_nm_q;
	assign result.done_res       = out_done_q;
	assign result.distance_error = out_err_q;

	// Status to the controller
	always_comb begin
		stat            = '0;
		stat.item_taken = capture;
		stat.single     = is_load || done_now || no_bits || literal;
		stat.out_free   = out_free;
		stat.can_issue  = (cnt_q != CNT_W'(LANE_BYTES)) && (rem_q != '0);
		stat.s1_busy    = s1_valid_s1;
		stat.rem_zero   = (rem_q == '0);
	end

endmodule

FILE: design/yay0_decompressor.sv
// Yay0 LZ decoder core. Mask loads, done/empty decodes and literals are latched, then
// decoded in the dispatch state straight into the registered result. A back-copy reads
// the single read port of the 4096-byte history (one byte a cycle), pausing after each
// lane until its last read lands and a held result is taken, then flushing it. The
// next request is taken once the last result of the current one is registered. Reset
// clears position, mask and size; the history RAM is not cleared.
module yay0_decompressor #(
	parameter int LANE_BYTES = yay0_pkg::LANE_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	yay0_in_if.sink                     feed,
	yay0_out_if.source                  result,
	input  logic                        cfg_wr_en,
	input  logic [yay0_pkg::POS_W-1:0]  cfg_wr_data
);
	import yay0_pkg::*;

	ctrl_cmd_t  cmd;
	dp_status_t stat;

	// Sequencer
	yay0_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.stat  (stat),
		.cmd   (cmd)
	);

	// Datapath
	yay0_dp #(
		.LANE_BYTES(LANE_BYTES)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.feed       (feed),
		.result     (result),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.cmd        (cmd),
		.stat       (stat)
	);

	// Reads are only issued while the lane has room and bytes remain
	a_issue_in_lane: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.issue |-> stat.can_issue)
		else $error("history read issued past lane or copy end");

	// A pending result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.single_out || cmd.flush_out) |-> stat.out_free)
		else $error("result register loaded while still held");

	// Empty results only come from one-result requests
	a_empty_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.byte_count == '0) |-> result.last_of_run)
		else $error("empty result not marked last");

endmodule
